// ===== design/bur_pkg.sv =====
// Shared types, codes and defaults for the bounded undo/redo stack pair.
package bur_pkg;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed widths of the request and response fields.
  localparam int FUNC_BITS         = 3;
  localparam int SYMBOL_FIELD_BITS = 8;
  localparam int STATUS_BITS       = 2;
  localparam int DEPTH_FIELD_BITS  = 5;

  // Command codes carried in the func field.
  localparam logic [FUNC_BITS-1:0] FUNC_RECORD     = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_UNDO       = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_REDO       = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DRAIN_UNDO = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_DRAIN_REDO = 3'd4;

  // Status codes returned with each response.
  localparam logic [STATUS_BITS-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_HALTED = 2'd2;

  typedef struct packed {
    logic [FUNC_BITS-1:0]         func;
    logic [SYMBOL_FIELD_BITS-1:0] symbol;
  } bur_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic [SYMBOL_FIELD_BITS-1:0] moved_symbol;
    logic [DEPTH_FIELD_BITS-1:0]  undo_depth;
    logic [DEPTH_FIELD_BITS-1:0]  redo_depth;
  } bur_rsp_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } bur_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } bur_cmd_t;

  // Operations applied to one stack.
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
    logic clear;
  } bur_stack_op_t;

endpackage

// ===== design/bounded_undo_redo_stacks_unit.sv =====
// Top level of the bounded undo/redo stack pair.
// An accepted request is held and executes once the response register is free, and
// its response is registered. No new request is taken until it has executed; the stack
// memories are read in the accept cycle and updated in the execute cycle.
// Reset (synchronous): both stacks empty, top pointers at the last slot, halt cleared.
// Stack memory contents are not cleared; only slots that were written are used.
module bounded_undo_redo_stacks_unit #(
  parameter int STACK_DEPTH = bur_pkg::STACK_DEPTH_DEF,
  parameter int SYMBOL_BITS = bur_pkg::SYMBOL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bur_pkg::bur_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bur_pkg::bur_rsp_t rsp_data
);

  import bur_pkg::*;

  bur_cmd_t cmd;

  // Sequencing.
  bur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // Stacks and response.
  bur_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_data (req_data),
    .rsp_data (rsp_data)
  );

endmodule

// ===== design/bur_stack.sv =====
// One bounded circular stack: symbol memory, wrapping top pointer and entry count.
module bur_stack #(
  parameter int STACK_DEPTH = bur_pkg::STACK_DEPTH_DEF,
  parameter int SYMBOL_BITS = bur_pkg::SYMBOL_BITS_DEF,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bur_pkg::bur_stack_op_t op,
  input  logic [SYMBOL_BITS-1:0] push_data,
  output logic [SYMBOL_BITS-1:0] top_data,
  output logic [CW-1:0]          count
);

  localparam int PW = $clog2(STACK_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(STACK_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [PW:0]   DEPTH_EXT  = (PW + 1)'(STACK_DEPTH);

  logic [SYMBOL_BITS-1:0] mem [STACK_DEPTH];
  logic [PW-1:0] top;
  logic [PW-1:0] top_next;
  logic [PW-1:0] top_inc;
  logic [PW-1:0] top_dec;
  logic [PW-1:0] drop;
  logic [PW:0]   rewind;
  logic [CW-1:0] count_next;

  // Neighbouring slots of the top, wrapping at the last slot.
  assign top_inc = (top == LAST_SLOT) ? '0 : top + 1'b1;
  assign top_dec = (top == '0) ? LAST_SLOT : top - 1'b1;

  // Clearing steps the top back over every held entry, modulo the depth.
  assign drop   = (count == FULL_COUNT) ? '0 : count[PW-1:0];
  assign rewind = (top >= drop) ? ({1'b0, top} - {1'b0, drop})
                                : ({1'b0, top} + DEPTH_EXT - {1'b0, drop});

  // Pointer and count update for the requested operation.
  always_comb begin
    top_next   = top;
    count_next = count;
    if (op.push) begin
      top_next   = top_inc;
      count_next = (count == FULL_COUNT) ? count : count + 1'b1;
    end else if (op.pop) begin
      top_next   = top_dec;
      count_next = count - 1'b1;
    end else if (op.clear) begin
      top_next   = rewind[PW-1:0];
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= LAST_SLOT;
      count <= '0;
    end else begin
      top   <= top_next;
      count <= count_next;
    end
  end

  // Symbol memory: a push writes the slot above the top; the top is read ahead.
  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[top_inc] <= push_data;
    end
    if (op.rd) begin
      top_data <= mem[top];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("stack count exceeds depth");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    op.pop |-> count != '0)
    else $error("pop issued on an empty stack");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({op.push, op.pop, op.clear}))
    else $error("more than one stack update in a cycle");
`endif

endmodule

// ===== design/bur_datapath.sv =====
// Datapath: request hold register, the two stacks, halt flag and response register.
module bur_datapath #(
  parameter int STACK_DEPTH = bur_pkg::STACK_DEPTH_DEF,
  parameter int SYMBOL_BITS = bur_pkg::SYMBOL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bur_pkg::bur_cmd_t cmd,
  input  bur_pkg::bur_req_t req_data,
  output bur_pkg::bur_rsp_t rsp_data
);

  import bur_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  bur_req_t                req_hold;
  logic                    halted;
  logic                    halted_next;
  logic [STATUS_BITS-1:0]  status;
  logic [STATUS_BITS-1:0]  status_next;
  logic [SYMBOL_BITS-1:0]  moved;
  logic [SYMBOL_BITS-1:0]  moved_next;
  logic [SYMBOL_BITS-1:0]  sym;
  bur_stack_op_t           undo_op;
  bur_stack_op_t           redo_op;
  logic [SYMBOL_BITS-1:0]  undo_push_data;
  logic [SYMBOL_BITS-1:0]  redo_push_data;
  logic [SYMBOL_BITS-1:0]  undo_top_data;
  logic [SYMBOL_BITS-1:0]  redo_top_data;
  logic [CW-1:0]           undo_count;
  logic [CW-1:0]           redo_count;

  assign sym = SYMBOL_BITS'(req_hold.symbol);

  bur_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_undo (
    .clk       (clk),
    .rst       (rst),
    .op        (undo_op),
    .push_data (undo_push_data),
    .top_data  (undo_top_data),
    .count     (undo_count)
  );

  bur_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_redo (
    .clk       (clk),
    .rst       (rst),
    .op        (redo_op),
    .push_data (redo_push_data),
    .top_data  (redo_top_data),
    .count     (redo_count)
  );

  // Decode the held request into stack operations and the response.
  always_comb begin
    undo_op        = '0;
    redo_op        = '0;
    undo_op.rd     = cmd.load;
    redo_op.rd     = cmd.load;
    undo_push_data = redo_top_data;
    redo_push_data = undo_top_data;
    status_next    = STATUS_DONE;
    moved_next     = '0;
    halted_next    = halted;
    if (cmd.exec) begin
      if (halted) begin
        status_next = STATUS_HALTED;
      end else begin
        case (req_hold.func)
          FUNC_RECORD: begin
            undo_op.push   = 1'b1;
            undo_push_data = sym;
            redo_op.clear  = 1'b1;
          end
          FUNC_UNDO: begin
            if (undo_count == '0) begin
              status_next = STATUS_EMPTY;
              halted_next = 1'b1;
            end else begin
              undo_op.pop  = 1'b1;
              redo_op.push = 1'b1;
              moved_next   = undo_top_data;
            end
          end
          FUNC_REDO: begin
            if (redo_count == '0) begin
              status_next = STATUS_EMPTY;
              halted_next = 1'b1;
            end else begin
              redo_op.pop  = 1'b1;
              undo_op.push = 1'b1;
              moved_next   = redo_top_data;
            end
          end
          FUNC_DRAIN_UNDO: begin
            if (undo_count != '0) begin
              undo_op.pop = 1'b1;
              moved_next  = undo_top_data;
            end
          end
          FUNC_DRAIN_REDO: begin
            if (redo_count != '0) begin
              redo_op.pop = 1'b1;
              moved_next  = redo_top_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Halt flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else begin
      halted <= halted_next;
    end
  end

  // Request hold and response payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_hold <= req_data;
    end
    if (cmd.exec) begin
      status <= status_next;
      moved  <= moved_next;
    end
  end

  // The counts stay put while a response waits, so they are read live.
  assign rsp_data.status       = status;
  assign rsp_data.moved_symbol = SYMBOL_FIELD_BITS'(moved);
  assign rsp_data.undo_depth   = DEPTH_FIELD_BITS'(undo_count);
  assign rsp_data.redo_depth   = DEPTH_FIELD_BITS'(redo_count);

endmodule

// ===== design/bur_ctrl.sv =====
// Controller: request acceptance, execute sequencing and response valid.
module bur_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bur_pkg::bur_cmd_t cmd
);

  import bur_pkg::*;

  bur_state_t state;
  bur_state_t state_next;
  logic       rsp_valid_next;
  logic       rsp_free;

  // The response register can be loaded when empty or being emptied.
  assign rsp_free = !rsp_valid || rsp_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.exec = rsp_free;
      end
      default: begin
      end
    endcase
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC) && !req_ready)
    else $error("accepted request did not move to execute");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("execute did not present a response");

  a_load_exec_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.exec))
    else $error("load and execute issued together");
`endif

endmodule

// ===== tb/bur_history_check.sv =====
// Checker for the undo/redo stack pair: tracks both histories and compares every response.
module bur_history_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  bur_pkg::bur_req_t req_data,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  bur_pkg::bur_rsp_t rsp_data,
  output int                outstanding,
  output int                error_count
);

  import bur_pkg::*;

  localparam int DEPTH    = STACK_DEPTH_DEF;
  localparam int TOP_BITS = $clog2(DEPTH);

  // Own copy of both histories, their top pointers, fill levels and the halt flag.
  logic [SYMBOL_FIELD_BITS-1:0] undo_mem [DEPTH];
  logic [SYMBOL_FIELD_BITS-1:0] redo_mem [DEPTH];
  logic [TOP_BITS-1:0]          undo_top;
  logic [TOP_BITS-1:0]          redo_top;
  logic [DEPTH_FIELD_BITS-1:0]  undo_cnt;
  logic [DEPTH_FIELD_BITS-1:0]  redo_cnt;
  logic                         halted;

  // Responses owed by the block, oldest first.
  bur_rsp_t owed_rsp [$];
  int       mismatches;

  // A push onto a full history advances the top and overwrites the oldest entry.
  function automatic void push_undo(input logic [SYMBOL_FIELD_BITS-1:0] v);
    undo_top           = undo_top + 1'b1;
    undo_mem[undo_top] = v;
    if (undo_cnt < DEPTH) undo_cnt = undo_cnt + 1'b1;
  endfunction

  function automatic void push_redo(input logic [SYMBOL_FIELD_BITS-1:0] v);
    redo_top           = redo_top + 1'b1;
    redo_mem[redo_top] = v;
    if (redo_cnt < DEPTH) redo_cnt = redo_cnt + 1'b1;
  endfunction

  function automatic logic [SYMBOL_FIELD_BITS-1:0] pop_undo();
    logic [SYMBOL_FIELD_BITS-1:0] v;
    v        = undo_mem[undo_top];
    undo_top = undo_top - 1'b1;
    undo_cnt = undo_cnt - 1'b1;
    return v;
  endfunction

  function automatic logic [SYMBOL_FIELD_BITS-1:0] pop_redo();
    logic [SYMBOL_FIELD_BITS-1:0] v;
    v        = redo_mem[redo_top];
    redo_top = redo_top - 1'b1;
    redo_cnt = redo_cnt - 1'b1;
    return v;
  endfunction

  // Applies one command to the histories and returns the response it should produce.
  function automatic bur_rsp_t apply_edit(input bur_req_t r);
    bur_rsp_t                     e;
    logic [SYMBOL_FIELD_BITS-1:0] sym;
    e   = '0;
    sym = '0;
    if (halted) begin
      e.status = STATUS_HALTED;
    end else begin
      case (r.func)
        FUNC_RECORD: begin
          // Recording discards the redo history; its top steps back over it.
          push_undo(r.symbol);
          redo_top = redo_top - redo_cnt[TOP_BITS-1:0];
          redo_cnt = '0;
        end
        FUNC_UNDO: begin
          if (undo_cnt == 0) begin
            e.status = STATUS_EMPTY;
            halted   = 1'b1;
          end else begin
            sym = pop_undo();
            push_redo(sym);
          end
        end
        FUNC_REDO: begin
          if (redo_cnt == 0) begin
            e.status = STATUS_EMPTY;
            halted   = 1'b1;
          end else begin
            sym = pop_redo();
            push_undo(sym);
          end
        end
        FUNC_DRAIN_UNDO: begin
          if (undo_cnt != 0) sym = pop_undo();
        end
        FUNC_DRAIN_REDO: begin
          if (redo_cnt != 0) sym = pop_redo();
        end
        default: begin
        end
      endcase
    end
    e.moved_symbol = sym;
    e.undo_depth   = undo_cnt;
    e.redo_depth   = redo_cnt;
    return e;
  endfunction

  // Both channels are sampled at the rising edge; responses are checked before
  // the request of the same edge is applied, as a response always belongs to
  // an earlier request.
  always @(posedge clk) begin
    bur_rsp_t e;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        undo_mem[i] = '0;
        redo_mem[i] = '0;
      end
      undo_top = TOP_BITS'(DEPTH - 1);
      redo_top = TOP_BITS'(DEPTH - 1);
      undo_cnt = '0;
      redo_cnt = '0;
      halted   = 1'b0;
      owed_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] response with none owed: status %0d symbol %0h depths %0d/%0d",
                     $realtime, rsp_data.status, rsp_data.moved_symbol,
                     rsp_data.undo_depth, rsp_data.redo_depth);
        end else begin
          e = owed_rsp.pop_front();
          if (e.status !== rsp_data.status || e.moved_symbol !== rsp_data.moved_symbol ||
              e.undo_depth !== rsp_data.undo_depth || e.redo_depth !== rsp_data.redo_depth) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: status %0d/%0d symbol %0h/%0h undo %0d/%0d redo %0d/%0d",
                       $realtime, e.status, rsp_data.status, e.moved_symbol,
                       rsp_data.moved_symbol, e.undo_depth, rsp_data.undo_depth,
                       e.redo_depth, rsp_data.redo_depth);
          end
        end
      end
      if (req_valid && req_ready) owed_rsp.push_back(apply_edit(req_data));
    end
    outstanding <= owed_rsp.size();
    error_count <= mismatches;
  end

endmodule

// ===== tb/tb_bounded_undo_redo_stacks_unit.sv =====
// Testbench top for the undo/redo stack pair: drives requests and gives the verdict.
module tb_bounded_undo_redo_stacks_unit;
  import bur_pkg::*;

  localparam int DEPTH             = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS      = 1350;
  localparam int PAUSE_AT          = 700;
  localparam int HOLD_AT           = 400;
  localparam int HOLD_CYCLES       = 80;
  localparam int STALL_LIMIT       = 2000;
  localparam int FIRST_UNUSED_FUNC = FUNC_DRAIN_REDO + 1;
  localparam int LAST_UNUSED_FUNC  = (1 << FUNC_BITS) - 1;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bur_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  bur_rsp_t rsp_data;
  int       outstanding;
  int       error_count;

  // Fill levels as the stimulus sees them, used to keep the block from halting early.
  int undo_fill = 0;
  int redo_fill = 0;
  int sent      = 0;
  int taken     = 0;

  always #1 clk = ~clk;

  bounded_undo_redo_stacks_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  bur_history_check u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .outstanding (outstanding),
    .error_count (error_count)
  );

  function automatic bur_req_t mk(input logic [FUNC_BITS-1:0] f,
                                  input logic [SYMBOL_FIELD_BITS-1:0] s);
    bur_req_t r;
    r.func   = f;
    r.symbol = s;
    return r;
  endfunction

  // Follows the fill levels of both histories for a request that was accepted.
  function automatic void track_fill(input bur_req_t r);
    case (r.func)
      FUNC_RECORD: begin
        if (undo_fill < DEPTH) undo_fill++;
        redo_fill = 0;
      end
      FUNC_UNDO: begin
        if (undo_fill > 0) begin
          undo_fill--;
          if (redo_fill < DEPTH) redo_fill++;
        end
      end
      FUNC_REDO: begin
        if (redo_fill > 0) begin
          redo_fill--;
          if (undo_fill < DEPTH) undo_fill++;
        end
      end
      FUNC_DRAIN_UNDO: begin
        if (undo_fill > 0) undo_fill--;
      end
      FUNC_DRAIN_REDO: begin
        if (redo_fill > 0) redo_fill--;
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly well-formed edits; undo and redo only go to a non-empty history.
  function automatic bur_req_t next_edit(input int rec_share);
    bur_req_t r;
    int       roll;
    r.symbol = SYMBOL_FIELD_BITS'($urandom_range(0, 255));
    r.func   = FUNC_RECORD;
    if ($urandom_range(0, 99) >= rec_share) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        if (undo_fill > 0)      r.func = FUNC_UNDO;
        else if (redo_fill > 0) r.func = FUNC_REDO;
      end else if (roll < 70) begin
        if (redo_fill > 0)      r.func = FUNC_REDO;
        else if (undo_fill > 0) r.func = FUNC_UNDO;
      end else if (roll < 82) begin
        r.func = FUNC_DRAIN_UNDO;
      end else if (roll < 94) begin
        r.func = FUNC_DRAIN_REDO;
      end else begin
        r.func = FUNC_BITS'($urandom_range(FIRST_UNUSED_FUNC, LAST_UNUSED_FUNC));
      end
    end
    return r;
  endfunction

  // Offers one request after a random gap, or after the block has gone quiet
  // at the pause point, and holds it until it is accepted.
  task automatic offer(input bur_req_t r);
    int gap;
    gap = ((sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 6);
    if (sent == PAUSE_AT) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end else if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    track_fill(r);
    sent++;
  endtask

  // Response side: random stalls, one long hold-off, and stretches without stalls.
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else if ((taken / 120) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Request stimulus and verdict.
  initial begin
    logic [SYMBOL_FIELD_BITS-1:0] fill_syms [17] = '{
      8'h00, 8'hFF, 8'h61, 8'h7A, 8'h55, 8'h52, 8'h0A, 8'hA5, 8'h5A,
      8'h01, 8'h80, 8'h7F, 8'hFE, 8'h33, 8'hCC, 8'h0F, 8'hF0};
    int rec_share;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Draining empty histories and the unused command codes.
    offer(mk(FUNC_DRAIN_UNDO, 8'hFF));
    offer(mk(FUNC_DRAIN_REDO, 8'hFF));
    for (int f = FIRST_UNUSED_FUNC; f <= LAST_UNUSED_FUNC; f++)
      offer(mk(FUNC_BITS'(f), SYMBOL_FIELD_BITS'($urandom_range(0, 255))));

    // One record more than the depth, so the oldest entry is overwritten.
    for (int i = 0; i < 17; i++) offer(mk(FUNC_RECORD, fill_syms[i]));

    // Two undos, a redo, a record that throws the remaining redo entry away, then a drain of each.
    offer(mk(FUNC_UNDO, 8'h00));
    offer(mk(FUNC_UNDO, 8'hFF));
    offer(mk(FUNC_REDO, 8'h00));
    offer(mk(FUNC_RECORD, 8'h3C));
    offer(mk(FUNC_DRAIN_UNDO, 8'h00));
    offer(mk(FUNC_DRAIN_REDO, 8'h00));

    // Random edits, with the share of records changing every 64 requests.
    rec_share = 35;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       rec_share = 20;
          1:       rec_share = 35;
          default: rec_share = 55;
        endcase
      end
      offer(next_edit(rec_share));
    end

    // Empty both histories, then undo or redo on an empty one halts the block.
    while (undo_fill > 0) offer(mk(FUNC_DRAIN_UNDO, SYMBOL_FIELD_BITS'($urandom_range(0, 255))));
    while (redo_fill > 0) offer(mk(FUNC_DRAIN_REDO, SYMBOL_FIELD_BITS'($urandom_range(0, 255))));
    offer(mk($urandom_range(0, 1) ? FUNC_UNDO : FUNC_REDO, 8'h00));

    // Every command code is ignored once halted.
    for (int f = 0; f <= LAST_UNUSED_FUNC; f++)
      offer(mk(FUNC_BITS'(f), SYMBOL_FIELD_BITS'($urandom_range(0, 255))));

    // Let the last responses drain.
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bur_pkg.sv
design/bur_stack.sv
design/bur_datapath.sv
design/bur_ctrl.sv
design/bounded_undo_redo_stacks_unit.sv
tb/bur_history_check.sv
tb/tb_bounded_undo_redo_stacks_unit.sv
